// ===== design/ctok_pkg.sv =====
// shared types, codes and character helpers for the c source tokenizer
package ctok_pkg;

  localparam int OffsetBitsDef   = 24;
  localparam int KeywordCharsDef = 7;
  localparam int QueueDepth      = 4;
  localparam int MaxRecs         = 3;
  localparam int NumKeywords     = 10;

  // token kinds
  localparam logic [5:0] K_NEWLINE   = 6'd0;
  localparam logic [5:0] K_LPAREN    = 6'd1;
  localparam logic [5:0] K_RPAREN    = 6'd2;
  localparam logic [5:0] K_LBRACKET  = 6'd3;
  localparam logic [5:0] K_RBRACKET  = 6'd4;
  localparam logic [5:0] K_LBRACE    = 6'd5;
  localparam logic [5:0] K_RBRACE    = 6'd6;
  localparam logic [5:0] K_BACKSLASH = 6'd7;
  localparam logic [5:0] K_SEMI      = 6'd8;
  localparam logic [5:0] K_INCDEC    = 6'd9;
  localparam logic [5:0] K_ASSIGN    = 6'd10;
  localparam logic [5:0] K_OPER      = 6'd11;
  localparam logic [5:0] K_ARROW     = 6'd12;
  localparam logic [5:0] K_DOLLAR    = 6'd13;
  localparam logic [5:0] K_STAR      = 6'd14;
  localparam logic [5:0] K_AMP       = 6'd15;
  localparam logic [5:0] K_COMPARE   = 6'd16;
  localparam logic [5:0] K_LANGLE    = 6'd17;
  localparam logic [5:0] K_RANGLE    = 6'd18;
  localparam logic [5:0] K_COLON     = 6'd19;
  localparam logic [5:0] K_CHAR      = 6'd20;
  localparam logic [5:0] K_STRING    = 6'd21;
  localparam logic [5:0] K_HASH      = 6'd22;
  localparam logic [5:0] K_DHASH     = 6'd23;
  localparam logic [5:0] K_QUEST     = 6'd24;
  localparam logic [5:0] K_COMMA     = 6'd25;
  localparam logic [5:0] K_DOT       = 6'd26;
  localparam logic [5:0] K_ELLIPSIS  = 6'd27;
  localparam logic [5:0] K_EOF       = 6'd28;
  localparam logic [5:0] K_IDENT     = 6'd29;
  localparam logic [5:0] K_NUM       = 6'd30;
  localparam logic [5:0] K_KW_FIRST  = 6'd31;
  localparam logic [5:0] K_ERROR     = 6'd41;

  // error codes
  localparam logic [2:0] E_NONE    = 3'd0;
  localparam logic [2:0] E_SYMBOL  = 3'd1;
  localparam logic [2:0] E_DOTS    = 3'd2;
  localparam logic [2:0] E_COMMENT = 3'd3;
  localparam logic [2:0] E_STRING  = 3'd4;
  localparam logic [2:0] E_CHARLIT = 3'd5;

  // control characters
  localparam logic [7:0] C_NUL = 8'h00;
  localparam logic [7:0] C_TAB = 8'h09;
  localparam logic [7:0] C_LF  = 8'h0A;
  localparam logic [7:0] C_VT  = 8'h0B;
  localparam logic [7:0] C_FF  = 8'h0C;
  localparam logic [7:0] C_CR  = 8'h0D;

  typedef enum logic [22:0] {
    M_IDLE     = 23'h000001,
    M_NL_CR    = 23'h000002,
    M_NL_TAIL  = 23'h000004,
    M_PLUS     = 23'h000008,
    M_MINUS    = 23'h000010,
    M_SLASH    = 23'h000020,
    M_PCTC     = 23'h000040,
    M_BAR      = 23'h000080,
    M_STAR     = 23'h000100,
    M_AMP      = 23'h000200,
    M_ANGLE1   = 23'h000400,
    M_ANGLE2   = 23'h000800,
    M_BANG     = 23'h001000,
    M_EQ       = 23'h002000,
    M_HASH     = 23'h004000,
    M_DOT1     = 23'h008000,
    M_DOT2     = 23'h010000,
    M_IDENT    = 23'h020000,
    M_NUM      = 23'h040000,
    M_CHARLIT  = 23'h080000,
    M_STR      = 23'h100000,
    M_LCOMMENT = 23'h200000,
    M_BCOMMENT = 23'h400000
  } mode_e;

  // keyword text, first character in the most significant used byte
  localparam logic [55:0] KwText [NumKeywords] = '{
    56'("case"), 56'("default"), 56'("do"), 56'("else"), 56'("enum"),
    56'("for"), 56'("while"), 56'("if"), 56'("struct"), 56'("switch")
  };
  localparam logic [3:0] KwLen [NumKeywords] = '{
    4'd4, 4'd7, 4'd2, 4'd4, 4'd4, 4'd3, 4'd5, 4'd2, 4'd6, 4'd6
  };

  typedef struct packed {
    logic [7:0] char_code;
  } in_word_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [2:0]  error_code;
    logic [23:0] start_offset;
    logic [23:0] token_length;
    logic        last_of_run;
  } out_word_t;

  // words produced by one byte, toward the output queue
  typedef struct packed {
    logic [1:0]          count;
    out_word_t [MaxRecs-1:0] recs;
  } push_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == " " || c == C_TAB;
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == "_";
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F") ||
           c == "l" || c == "L" || c == "u" || c == "U" || c == "x" || c == "X";
  endfunction

  function automatic logic is_exp(input logic [7:0] c);
    return c == "e" || c == "E" || c == "p" || c == "P";
  endfunction

endpackage

// ===== design/ctok_word_if.sv =====
// valid/ready channel carrying one word of a given payload type
interface ctok_word_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/ctok_core.sv =====
// lexer state registers and the per-byte token decision logic
module ctok_core #(
  parameter int OFFSET_BITS   = ctok_pkg::OffsetBitsDef,
  parameter int KEYWORD_CHARS = ctok_pkg::KeywordCharsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            take_i,
  input  logic [7:0]      char_i,
  output ctok_pkg::push_t push_o
);
  import ctok_pkg::*;

  localparam int LW = OFFSET_BITS + 1;
  localparam int WB = 8 * KEYWORD_CHARS;

  mode_e            mode_q, mode_d;
  logic [OFFSET_BITS-1:0] start_q, start_d, pos_q, pos_d;
  logic [WB-1:0]    wbuf_q, wbuf_d;
  logic [3:0]       wlen_q, wlen_d;
  logic             ang_q, ang_d;
  logic [2:0]       phase_q, phase_d;

  logic [LW-1:0]    st_tok, st_pos, len_ex, len_in;
  logic [5:0]       word_kind;

  function automatic logic [23:0] sat24(input logic [LW-1:0] v);
    logic [32:0] w;
    w = 33'(v);
    return (w > 33'h0FFFFFF) ? 24'hFFFFFF : w[23:0];
  endfunction

  function automatic out_word_t mk(input logic [5:0] k, input logic [2:0] e,
                                   input logic [LW-1:0] s, input logic [LW-1:0] l);
    out_word_t r;
    r.token_kind   = k;
    r.error_code   = e;
    r.start_offset = sat24(s);
    r.token_length = sat24(l);
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  assign st_tok = {1'b0, start_q};
  assign st_pos = {1'b0, pos_q};
  assign len_ex = st_pos - st_tok;
  assign len_in = len_ex + LW'(1);

  // keyword lookup over the collected identifier prefix
  always_comb begin
    logic same;
    word_kind = K_IDENT;
    for (int k = NumKeywords - 1; k >= 0; k--) begin
      same = (wlen_q == KwLen[k]);
      for (int i = 0; i < 7; i++) begin
        if (i < int'(KwLen[k]) &&
            wbuf_q[8*i +: 8] != KwText[k][8*(int'(KwLen[k])-1-i) +: 8]) begin
          same = 1'b0;
        end
      end
      if (same) word_kind = K_KW_FIRST + 6'(k);
    end
  end

  always_comb begin
    logic [7:0] c;
    logic       fresh;
    logic       eof;
    logic [1:0] n;
    logic       num, ex, sgn;
    out_word_t  recs [MaxRecs];
    c       = char_i;
    fresh   = 1'b0;
    eof     = 1'b0;
    n       = 2'd0;
    num     = is_num(c);
    ex      = is_exp(c);
    sgn     = (c == "+") || (c == "-");
    mode_d  = mode_q;
    start_d = start_q;
    wbuf_d  = wbuf_q;
    wlen_d  = wlen_q;
    ang_d   = ang_q;
    phase_d = phase_q;
    for (int r = 0; r < MaxRecs; r++) recs[r] = '0;

    if (take_i) begin
      if (mode_q == M_IDLE) begin
        fresh = 1'b1;
      end else begin
        unique case (mode_q)
          M_NL_CR: begin
            if (c == C_LF || is_blank(c)) mode_d = M_NL_TAIL;
            else begin
              recs[n] = mk(K_NEWLINE, E_NONE, st_tok, len_ex); n = n + 2'd1;
              mode_d = M_IDLE; fresh = 1'b1;
            end
          end
          M_NL_TAIL: begin
            if (!is_blank(c)) begin
              recs[n] = mk(K_NEWLINE, E_NONE, st_tok, len_ex); n = n + 2'd1;
              mode_d = M_IDLE; fresh = 1'b1;
            end
          end
          M_PLUS: begin
            mode_d = M_IDLE;
            if (c == "+") begin
              recs[n] = mk(K_INCDEC, E_NONE, st_tok, len_in); n = n + 2'd1;
            end else if (c == "=") begin
              recs[n] = mk(K_ASSIGN, E_NONE, st_tok, len_in); n = n + 2'd1;
            end else begin
              recs[n] = mk(K_OPER, E_NONE, st_tok, len_ex); n = n + 2'd1; fresh = 1'b1;
            end
          end
          M_MINUS: begin
            mode_d = M_IDLE;
            if (c == "-") begin
              recs[n] = mk(K_INCDEC, E_NONE, st_tok, len_in); n = n + 2'd1;
            end else if (c == ">") begin
              recs[n] = mk(K_ARROW, E_NONE, st_tok, len_in); n = n + 2'd1;
            end else if (c == "=") begin
              recs[n] = mk(K_ASSIGN, E_NONE, st_tok, len_in); n = n + 2'd1;
            end else begin
              recs[n] = mk(K_OPER, E_NONE, st_tok, len_ex); n = n + 2'd1; fresh = 1'b1;
            end
          end
          M_SLASH: begin
            if (c == "/") begin
              mode_d = M_LCOMMENT; phase_d = 3'd0;
            end else if (c == "*") begin
              mode_d = M_BCOMMENT; phase_d = 3'd0;
            end else if (c == "=") begin
              recs[n] = mk(K_ASSIGN, E_NONE, st_tok, len_in); n = n + 2'd1; mode_d = M_IDLE;
            end else begin
              recs[n] = mk(K_OPER, E_NONE, st_tok, len_ex); n = n + 2'd1;
              mode_d = M_IDLE; fresh = 1'b1;
            end
          end
          M_PCTC, M_BANG, M_EQ, M_STAR, M_HASH: begin
            mode_d = M_IDLE;
            if (mode_q == M_HASH && c == "#") begin
              recs[n] = mk(K_DHASH, E_NONE, st_tok, len_in); n = n + 2'd1;
            end else if (mode_q != M_HASH && c == "=") begin
              recs[n] = mk((mode_q == M_PCTC || mode_q == M_STAR) ? K_ASSIGN : K_COMPARE,
                           E_NONE, st_tok, len_in);
              n = n + 2'd1;
            end else begin
              recs[n] = mk((mode_q == M_EQ) ? K_ASSIGN : (mode_q == M_STAR) ? K_STAR :
                           (mode_q == M_HASH) ? K_HASH : K_OPER, E_NONE, st_tok, len_ex);
              n = n + 2'd1; fresh = 1'b1;
            end
          end
          M_BAR, M_AMP: begin
            mode_d = M_IDLE;
            if ((mode_q == M_BAR && c == "|") || (mode_q == M_AMP && c == "&")) begin
              recs[n] = mk(K_OPER, E_NONE, st_tok, len_in); n = n + 2'd1;
            end else if (c == "=") begin
              recs[n] = mk(K_ASSIGN, E_NONE, st_tok, len_in); n = n + 2'd1;
            end else begin
              recs[n] = mk((mode_q == M_AMP) ? K_AMP : K_OPER, E_NONE, st_tok, len_ex);
              n = n + 2'd1; fresh = 1'b1;
            end
          end
          M_ANGLE1: begin
            if (c == "=") begin
              recs[n] = mk(K_COMPARE, E_NONE, st_tok, len_in); n = n + 2'd1; mode_d = M_IDLE;
            end else if (c == (ang_q ? 8'("<") : 8'(">"))) begin
              mode_d = M_ANGLE2;
            end else begin
              recs[n] = mk(ang_q ? K_LANGLE : K_RANGLE, E_NONE, st_tok, len_ex);
              n = n + 2'd1; mode_d = M_IDLE; fresh = 1'b1;
            end
          end
          M_ANGLE2: begin
            mode_d = M_IDLE;
            if (c == "=") begin
              recs[n] = mk(K_ASSIGN, E_NONE, st_tok, len_in); n = n + 2'd1;
            end else begin
              recs[n] = mk(K_OPER, E_NONE, st_tok, len_ex); n = n + 2'd1; fresh = 1'b1;
            end
          end
          M_DOT1: begin
            if (c == ".") mode_d = M_DOT2;
            else begin
              recs[n] = mk(K_DOT, E_NONE, st_tok, len_ex); n = n + 2'd1;
              mode_d = M_IDLE; fresh = 1'b1;
            end
          end
          M_DOT2: begin
            mode_d = M_IDLE;
            if (c == ".") begin
              recs[n] = mk(K_ELLIPSIS, E_NONE, st_tok, len_in); n = n + 2'd1;
            end else begin
              recs[n] = mk(K_ERROR, E_DOTS, st_tok, len_ex); n = n + 2'd1;
              recs[n] = mk(K_DOT, E_NONE, st_tok, len_ex); n = n + 2'd1;
              fresh = 1'b1;
            end
          end
          M_IDENT: begin
            if (is_word(c)) begin
              if (wlen_q < 4'(KEYWORD_CHARS)) begin
                for (int i = 0; i < KEYWORD_CHARS; i++) begin
                  if (wlen_q == 4'(i)) wbuf_d[8*i +: 8] = c;
                end
                wlen_d = wlen_q + 4'd1;
              end else begin
                wlen_d = 4'(KEYWORD_CHARS + 1);
              end
            end else begin
              recs[n] = mk(word_kind, E_NONE, st_tok, len_ex); n = n + 2'd1;
              mode_d = M_IDLE; fresh = 1'b1;
            end
          end
          M_NUM: begin
            logic cont;
            cont = 1'b1;
            priority case (phase_q)
              3'd0: begin
                if (c == ".") phase_d = 3'd1;
                else if (ex) phase_d = 3'd2;
                else if (!num) cont = 1'b0;
              end
              3'd1: begin
                if (ex) phase_d = 3'd3;
                else if (!num) cont = 1'b0;
              end
              3'd2: begin
                if (sgn) phase_d = 3'd4;
                else if (c == ".") phase_d = 3'd1;
                else if (ex) phase_d = 3'd2;
                else if (num) phase_d = 3'd0;
                else cont = 1'b0;
              end
              3'd3: begin
                if (sgn) phase_d = 3'd4;
                else if (ex) phase_d = 3'd3;
                else if (num) phase_d = 3'd1;
                else cont = 1'b0;
              end
              default: begin
                if (!num) cont = 1'b0;
              end
            endcase
            if (!cont) begin
              recs[n] = mk(K_NUM, E_NONE, st_tok, len_ex); n = n + 2'd1;
              mode_d = M_IDLE; fresh = 1'b1;
            end
          end
          M_CHARLIT: begin
            if (c == C_NUL) begin
              recs[n] = mk(K_ERROR, E_CHARLIT, st_tok, len_ex); n = n + 2'd1;
              recs[n] = mk(K_CHAR, E_NONE, st_tok, len_ex); n = n + 2'd1;
              mode_d = M_IDLE; fresh = 1'b1;
            end else if (phase_q == 3'd0) begin
              phase_d = (c == "\\") ? 3'd1 : 3'd2;
            end else if (phase_q == 3'd1) begin
              phase_d = 3'd2;
            end else begin
              if (c != "'") begin
                recs[n] = mk(K_ERROR, E_CHARLIT, st_tok, len_in); n = n + 2'd1;
              end
              recs[n] = mk(K_CHAR, E_NONE, st_tok, len_in); n = n + 2'd1;
              mode_d = M_IDLE;
            end
          end
          M_STR: begin
            if (c == C_NUL) begin
              recs[n] = mk(K_ERROR, E_STRING, st_tok, len_ex); n = n + 2'd1;
              recs[n] = mk(K_STRING, E_NONE, st_tok, len_ex); n = n + 2'd1;
              mode_d = M_IDLE; fresh = 1'b1;
            end else if (phase_q != 3'd0) begin
              phase_d = 3'd0;
            end else if (c == "\\") begin
              phase_d = 3'd1;
            end else if (c == "\"") begin
              recs[n] = mk(K_STRING, E_NONE, st_tok, len_in); n = n + 2'd1;
              mode_d = M_IDLE;
            end
          end
          M_LCOMMENT: begin
            if (c == C_NUL) begin
              mode_d = M_IDLE; fresh = 1'b1;
            end else if (c == C_LF) begin
              // backslash continuation keeps the comment open
              if (phase_q != 3'd0) phase_d = 3'd0;
              else begin
                mode_d = M_IDLE; fresh = 1'b1;
              end
            end else if (c == "\\") begin
              phase_d = 3'd1;
            end else if (!(is_blank(c) || c == C_CR || c == C_VT || c == C_FF)) begin
              phase_d = 3'd0;
            end
          end
          M_BCOMMENT: begin
            if (c == C_NUL) begin
              recs[n] = mk(K_ERROR, E_COMMENT, st_tok, len_ex); n = n + 2'd1;
              mode_d = M_IDLE; fresh = 1'b1;
            end else if (c == "*") begin
              phase_d = 3'd1;
            end else if (c == "/" && phase_q != 3'd0) begin
              mode_d = M_IDLE;
            end else begin
              phase_d = 3'd0;
            end
          end
          default: begin
            mode_d = M_IDLE; fresh = 1'b1;
          end
        endcase
      end

      if (fresh) begin
        unique case (c)
          " ", C_TAB: ;
          C_CR: begin mode_d = M_NL_CR; start_d = pos_q; phase_d = 3'd0; end
          C_LF: begin mode_d = M_NL_TAIL; start_d = pos_q; phase_d = 3'd0; end
          "(": begin recs[n] = mk(K_LPAREN, E_NONE, st_pos, LW'(1)); n = n + 2'd1; end
          ")": begin recs[n] = mk(K_RPAREN, E_NONE, st_pos, LW'(1)); n = n + 2'd1; end
          "[": begin recs[n] = mk(K_LBRACKET, E_NONE, st_pos, LW'(1)); n = n + 2'd1; end
          "]": begin recs[n] = mk(K_RBRACKET, E_NONE, st_pos, LW'(1)); n = n + 2'd1; end
          "{": begin recs[n] = mk(K_LBRACE, E_NONE, st_pos, LW'(1)); n = n + 2'd1; end
          "}": begin recs[n] = mk(K_RBRACE, E_NONE, st_pos, LW'(1)); n = n + 2'd1; end
          "\\": begin recs[n] = mk(K_BACKSLASH, E_NONE, st_pos, LW'(1)); n = n + 2'd1; end
          ";": begin recs[n] = mk(K_SEMI, E_NONE, st_pos, LW'(1)); n = n + 2'd1; end
          "~": begin recs[n] = mk(K_OPER, E_NONE, st_pos, LW'(1)); n = n + 2'd1; end
          "$": begin recs[n] = mk(K_DOLLAR, E_NONE, st_pos, LW'(1)); n = n + 2'd1; end
          ":": begin recs[n] = mk(K_COLON, E_NONE, st_pos, LW'(1)); n = n + 2'd1; end
          "?": begin recs[n] = mk(K_QUEST, E_NONE, st_pos, LW'(1)); n = n + 2'd1; end
          ",": begin recs[n] = mk(K_COMMA, E_NONE, st_pos, LW'(1)); n = n + 2'd1; end
          "+": begin mode_d = M_PLUS; start_d = pos_q; phase_d = 3'd0; end
          "-": begin mode_d = M_MINUS; start_d = pos_q; phase_d = 3'd0; end
          "/": begin mode_d = M_SLASH; start_d = pos_q; phase_d = 3'd0; end
          "%", "^": begin mode_d = M_PCTC; start_d = pos_q; phase_d = 3'd0; end
          "|": begin mode_d = M_BAR; start_d = pos_q; phase_d = 3'd0; end
          "*": begin mode_d = M_STAR; start_d = pos_q; phase_d = 3'd0; end
          "&": begin mode_d = M_AMP; start_d = pos_q; phase_d = 3'd0; end
          "<", ">": begin
            mode_d = M_ANGLE1; start_d = pos_q; phase_d = 3'd0; ang_d = (c == "<");
          end
          "!": begin mode_d = M_BANG; start_d = pos_q; phase_d = 3'd0; end
          "=": begin mode_d = M_EQ; start_d = pos_q; phase_d = 3'd0; end
          "#": begin mode_d = M_HASH; start_d = pos_q; phase_d = 3'd0; end
          ".": begin mode_d = M_DOT1; start_d = pos_q; phase_d = 3'd0; end
          "'": begin mode_d = M_CHARLIT; start_d = pos_q; phase_d = 3'd0; end
          "\"": begin mode_d = M_STR; start_d = pos_q; phase_d = 3'd0; end
          C_NUL: begin
            recs[n] = mk(K_EOF, E_NONE, st_pos, LW'(0)); n = n + 2'd1;
            eof = 1'b1;
          end
          default: begin
            if (is_alpha(c) || c == "_") begin
              mode_d  = M_IDENT; start_d = pos_q; phase_d = 3'd0;
              wbuf_d  = WB'(c);
              wlen_d  = 4'd1;
            end else if (is_digit(c)) begin
              mode_d = M_NUM; start_d = pos_q; phase_d = 3'd0;
            end else begin
              recs[n] = mk(K_ERROR, E_SYMBOL, st_pos, LW'(1)); n = n + 2'd1;
            end
          end
        endcase
      end

      if (eof) begin
        mode_d  = M_IDLE;
        start_d = '0;
        pos_d   = '0;
        wbuf_d  = '0;
        wlen_d  = '0;
        ang_d   = 1'b0;
        phase_d = '0;
      end else begin
        pos_d = (pos_q != '1) ? pos_q + OFFSET_BITS'(1) : pos_q;
      end
    end else begin
      pos_d = pos_q;
    end

    for (int r = 0; r < MaxRecs; r++) begin
      recs[r].last_of_run = (2'(r) == n - 2'd1);
      push_o.recs[r] = recs[r];
    end
    push_o.count = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      start_q <= '0;
      pos_q   <= '0;
      wbuf_q  <= '0;
      wlen_q  <= '0;
      ang_q   <= 1'b0;
      phase_q <= '0;
    end else begin
      mode_q  <= mode_d;
      start_q <= start_d;
      pos_q   <= pos_d;
      wbuf_q  <= wbuf_d;
      wlen_q  <= wlen_d;
      ang_q   <= ang_d;
      phase_q <= phase_d;
    end
  end

endmodule

// ===== design/ctok_queue.sv =====
// small output queue taking up to three words per cycle and giving one
module ctok_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctok_pkg::push_t     push_i,
  input  logic                pop_i,
  output logic                valid_o,
  output ctok_pkg::out_word_t head_o,
  output logic                room_o
);
  import ctok_pkg::*;

  localparam int PW = $clog2(QueueDepth);

  out_word_t       mem_q [QueueDepth];
  logic [PW-1:0]   wp_q, rp_q;
  logic [PW:0]     cnt_q, cnt_d;

  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rp_q];
  // room for the largest burst one byte can cause
  assign room_o  = (cnt_q <= (PW+1)'(QueueDepth - MaxRecs));
  assign cnt_d   = cnt_q - (PW+1)'(pop_i && valid_o) + (PW+1)'(push_i.count);

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxRecs; k++) begin
      if (2'(k) < push_i.count) mem_q[wp_q + PW'(k)] <= push_i.recs[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + PW'(push_i.count);
      if (pop_i && valid_o) rp_q <= rp_q + PW'(1);
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== design/c_source_tokenizer_top.sv =====
// top level of the c source tokenizer: byte in, token words out
// latency: a token word is in the output queue the cycle after the byte that completes it
// throughput: one byte per cycle while the output side takes one word per cycle
// a byte producing two or three words stalls input until the queue holds
// at most one word again
// reset: asynchronous active low, lexer idle at offset zero, output queue empty
module c_source_tokenizer_top #(
  parameter int OFFSET_BITS   = ctok_pkg::OffsetBitsDef,
  parameter int KEYWORD_CHARS = ctok_pkg::KeywordCharsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ctok_word_if.sink   in_i,
  ctok_word_if.source out_o
);
  import ctok_pkg::*;

  push_t     push;
  logic      room;
  logic      take;
  out_word_t head;

  // input is taken whenever the queue can absorb a full burst
  assign in_i.ready = room;
  assign take       = in_i.valid && room;

  // lexer: state registers plus the decision logic for one byte
  ctok_core #(
    .OFFSET_BITS  (OFFSET_BITS),
    .KEYWORD_CHARS(KEYWORD_CHARS)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .take_i(take),
    .char_i(in_i.data.char_code),
    .push_o(push)
  );

  // output queue parts the two handshakes
  ctok_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (out_o.ready),
    .valid_o(out_o.valid),
    .head_o (head),
    .room_o (room)
  );

  assign out_o.data = head;

endmodule

// ===== design/ctok_checker.sv =====
// port-level checks on the tokenizer, bound to the top level
module ctok_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input ctok_pkg::out_word_t out_data_i
);
  import ctok_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("output word dropped or changed while stalled");

  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((out_data_i.token_kind == K_ERROR) == (out_data_i.error_code != E_NONE)))
    else $error("error code does not match error record");

  a_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.token_kind == K_EOF |->
      out_data_i.token_length == '0 && out_data_i.last_of_run)
    else $error("end token malformed");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.token_kind == K_ERROR && out_data_i.error_code != E_SYMBOL &&
      out_data_i.error_code != E_COMMENT && out_data_i.error_code != E_CHARLIT |->
      !out_data_i.last_of_run)
    else $error("dots or string error not followed by its token");

endmodule

bind c_source_tokenizer_top ctok_checker u_ctok_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_data_i (out_o.data)
);

// ===== verif/tb.sv =====
// self-checking testbench for the c source tokenizer top level
module tb;
  import ctok_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int LongHold   = 80;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ctok_word_if #(.T(in_word_t))  in_if ();
  ctok_word_if #(.T(out_word_t)) out_if ();

  c_source_tokenizer_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shared run state
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit          quiet = 1'b0;      // no idling on either side
  bit          hold_req = 1'b0;   // ask the receiver for one long hold-off
  out_word_t   tokens_due[$];     // expected token words, oldest first
  out_word_t   step_words[$];     // words caused by the byte being lexed

  // predictor state, mirrors the lexer registers
  mode_e       lx_mode;
  logic [23:0] lx_start;
  logic [23:0] lx_pos;
  logic [55:0] lx_wbuf;
  logic [3:0]  lx_wlen;
  logic        lx_left;
  logic [2:0]  lx_phase;

  string kw_names[NumKeywords] = '{"case", "default", "do", "else", "enum",
                                   "for", "while", "if", "struct", "switch"};

  function automatic void lex_clear();
    lx_mode  = M_IDLE;
    lx_start = '0;
    lx_pos   = '0;
    lx_wbuf  = '0;
    lx_wlen  = '0;
    lx_left  = 1'b0;
    lx_phase = '0;
  endfunction

  function automatic void emit(logic [5:0] k, logic [2:0] e, logic [23:0] s,
                               logic [24:0] n);
    out_word_t w;
    w.token_kind   = k;
    w.error_code   = e;
    w.start_offset = s;
    w.token_length = n[24] ? 24'hFFFFFF : n[23:0];
    w.last_of_run  = 1'b0;
    step_words = {step_words, w};
  endfunction

  function automatic logic [24:0] len_ex();
    return {1'b0, lx_pos - lx_start};
  endfunction

  function automatic logic [24:0] len_in();
    return {1'b0, lx_pos - lx_start} + 25'd1;
  endfunction

  function automatic void start_tok(mode_e m);
    lx_start = lx_pos;
    lx_mode  = m;
    lx_phase = '0;
  endfunction

  function automatic void close_in(logic [5:0] k);
    emit(k, E_NONE, lx_start, len_in());
    lx_mode = M_IDLE;
  endfunction

  // token ended before this byte: the byte is lexed again from idle
  function automatic logic close_ex(logic [5:0] k);
    emit(k, E_NONE, lx_start, len_ex());
    lx_mode = M_IDLE;
    return 1'b1;
  endfunction

  function automatic logic is_let(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_numc(logic [7:0] c);
    return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F") ||
           c == "l" || c == "L" || c == "u" || c == "U" || c == "x" || c == "X";
  endfunction

  function automatic logic is_expc(logic [7:0] c);
    return c == "e" || c == "E" || c == "p" || c == "P";
  endfunction

  function automatic void word_push(logic [7:0] c);
    if (lx_wlen < 4'd7) begin
      lx_wbuf[8*lx_wlen +: 8] = c;
      lx_wlen++;
    end else begin
      lx_wlen = 4'd8;
    end
  endfunction

  function automatic logic [5:0] word_class();
    bit same;
    for (int k = 0; k < NumKeywords; k++) begin
      same = (lx_wlen == kw_names[k].len());
      for (int i = 0; same && i < kw_names[k].len(); i++)
        if (lx_wbuf[8*i +: 8] != kw_names[k][i]) same = 0;
      if (same) return K_KW_FIRST + 6'(k);
    end
    return K_IDENT;
  endfunction

  // returns 1 on end of input
  function automatic logic lex_idle(logic [7:0] c);
    case (c)
      " ", C_TAB: ;
      C_CR: start_tok(M_NL_CR);
      C_LF: start_tok(M_NL_TAIL);
      "(": emit(K_LPAREN, E_NONE, lx_pos, 1);
      ")": emit(K_RPAREN, E_NONE, lx_pos, 1);
      "[": emit(K_LBRACKET, E_NONE, lx_pos, 1);
      "]": emit(K_RBRACKET, E_NONE, lx_pos, 1);
      "{": emit(K_LBRACE, E_NONE, lx_pos, 1);
      "}": emit(K_RBRACE, E_NONE, lx_pos, 1);
      "\\": emit(K_BACKSLASH, E_NONE, lx_pos, 1);
      ";": emit(K_SEMI, E_NONE, lx_pos, 1);
      "~": emit(K_OPER, E_NONE, lx_pos, 1);
      "$": emit(K_DOLLAR, E_NONE, lx_pos, 1);
      ":": emit(K_COLON, E_NONE, lx_pos, 1);
      "?": emit(K_QUEST, E_NONE, lx_pos, 1);
      ",": emit(K_COMMA, E_NONE, lx_pos, 1);
      "+": start_tok(M_PLUS);
      "-": start_tok(M_MINUS);
      "/": start_tok(M_SLASH);
      "%", "^": start_tok(M_PCTC);
      "|": start_tok(M_BAR);
      "*": start_tok(M_STAR);
      "&": start_tok(M_AMP);
      "<", ">": begin
        start_tok(M_ANGLE1);
        lx_left = (c == "<");
      end
      "!": start_tok(M_BANG);
      "=": start_tok(M_EQ);
      "#": start_tok(M_HASH);
      ".": start_tok(M_DOT1);
      "'": start_tok(M_CHARLIT);
      "\"": start_tok(M_STR);
      C_NUL: begin
        emit(K_EOF, E_NONE, lx_pos, 0);
        return 1'b1;
      end
      default: begin
        if (is_let(c) || c == "_") begin
          start_tok(M_IDENT);
          lx_wbuf = '0;
          lx_wlen = '0;
          word_push(c);
        end else if (is_dig(c)) begin
          start_tok(M_NUM);
        end else begin
          emit(K_ERROR, E_SYMBOL, lx_pos, 1);
        end
      end
    endcase
    return 1'b0;
  endfunction

  // pending token; returns 1 when the byte must be lexed again from idle
  function automatic logic lex_pending(logic [7:0] c);
    logic num, ex, sgn;
    num = is_numc(c);
    ex  = is_expc(c);
    sgn = (c == "+" || c == "-");
    case (lx_mode)
      M_NL_CR: begin
        if (c == C_LF || c == " " || c == C_TAB) begin
          lx_mode = M_NL_TAIL;
          return 1'b0;
        end
        return close_ex(K_NEWLINE);
      end
      M_NL_TAIL: begin
        if (c == " " || c == C_TAB) return 1'b0;
        return close_ex(K_NEWLINE);
      end
      M_PLUS: begin
        if (c == "+") close_in(K_INCDEC);
        else if (c == "=") close_in(K_ASSIGN);
        else return close_ex(K_OPER);
      end
      M_MINUS: begin
        if (c == "-") close_in(K_INCDEC);
        else if (c == ">") close_in(K_ARROW);
        else if (c == "=") close_in(K_ASSIGN);
        else return close_ex(K_OPER);
      end
      M_SLASH: begin
        if (c == "/") begin
          lx_mode = M_LCOMMENT;
          lx_phase = '0;
        end else if (c == "*") begin
          lx_mode = M_BCOMMENT;
          lx_phase = '0;
        end else if (c == "=") close_in(K_ASSIGN);
        else return close_ex(K_OPER);
      end
      M_PCTC: begin
        if (c == "=") close_in(K_ASSIGN);
        else return close_ex(K_OPER);
      end
      M_BAR: begin
        if (c == "|") close_in(K_OPER);
        else if (c == "=") close_in(K_ASSIGN);
        else return close_ex(K_OPER);
      end
      M_STAR: begin
        if (c == "=") close_in(K_ASSIGN);
        else return close_ex(K_STAR);
      end
      M_AMP: begin
        if (c == "&") close_in(K_OPER);
        else if (c == "=") close_in(K_ASSIGN);
        else return close_ex(K_AMP);
      end
      M_ANGLE1: begin
        if (c == "=") close_in(K_COMPARE);
        else if (c == (lx_left ? "<" : ">")) lx_mode = M_ANGLE2;
        else return close_ex(lx_left ? K_LANGLE : K_RANGLE);
      end
      M_ANGLE2: begin
        if (c == "=") close_in(K_ASSIGN);
        else return close_ex(K_OPER);
      end
      M_BANG: begin
        if (c == "=") close_in(K_COMPARE);
        else return close_ex(K_OPER);
      end
      M_EQ: begin
        if (c == "=") close_in(K_COMPARE);
        else return close_ex(K_ASSIGN);
      end
      M_HASH: begin
        if (c == "#") close_in(K_DHASH);
        else return close_ex(K_HASH);
      end
      M_DOT1: begin
        if (c == ".") lx_mode = M_DOT2;
        else return close_ex(K_DOT);
      end
      M_DOT2: begin
        if (c == ".") close_in(K_ELLIPSIS);
        else begin
          emit(K_ERROR, E_DOTS, lx_start, len_ex());
          return close_ex(K_DOT);
        end
      end
      M_IDENT: begin
        if (is_let(c) || is_dig(c) || c == "_") word_push(c);
        else return close_ex(word_class());
      end
      M_NUM: begin
        // phase 0 integer, 1 fraction, 2/3 after exponent letter, 4 after sign
        case (lx_phase)
          3'd0: begin
            if (c == ".") begin lx_phase = 3'd1; return 1'b0; end
            if (ex) begin lx_phase = 3'd2; return 1'b0; end
            if (num) return 1'b0;
          end
          3'd1: begin
            if (ex) begin lx_phase = 3'd3; return 1'b0; end
            if (num) return 1'b0;
          end
          3'd2: begin
            if (sgn) begin lx_phase = 3'd4; return 1'b0; end
            if (c == ".") begin lx_phase = 3'd1; return 1'b0; end
            if (ex) return 1'b0;
            if (num) begin lx_phase = 3'd0; return 1'b0; end
          end
          3'd3: begin
            if (sgn) begin lx_phase = 3'd4; return 1'b0; end
            if (ex) return 1'b0;
            if (num) begin lx_phase = 3'd1; return 1'b0; end
          end
          default: if (num) return 1'b0;
        endcase
        return close_ex(K_NUM);
      end
      M_CHARLIT: begin
        if (c == C_NUL) begin
          emit(K_ERROR, E_CHARLIT, lx_start, len_ex());
          return close_ex(K_CHAR);
        end
        if (lx_phase == 3'd0) lx_phase = (c == "\\") ? 3'd1 : 3'd2;
        else if (lx_phase == 3'd1) lx_phase = 3'd2;
        else begin
          if (c != "'") emit(K_ERROR, E_CHARLIT, lx_start, len_in());
          close_in(K_CHAR);
        end
      end
      M_STR: begin
        if (c == C_NUL) begin
          emit(K_ERROR, E_STRING, lx_start, len_ex());
          return close_ex(K_STRING);
        end
        if (lx_phase != 3'd0) lx_phase = 3'd0;
        else if (c == "\\") lx_phase = 3'd1;
        else if (c == "\"") close_in(K_STRING);
      end
      M_LCOMMENT: begin
        if (c == C_NUL) begin
          lx_mode = M_IDLE;
          return 1'b1;
        end
        if (c == C_LF) begin
          if (lx_phase != 3'd0) begin
            lx_phase = 3'd0;
            return 1'b0;
          end
          lx_mode = M_IDLE;
          return 1'b1;
        end
        if (c == "\\") lx_phase = 3'd1;
        else if (!(c == " " || c == C_TAB || c == C_CR || c == C_VT || c == C_FF))
          lx_phase = 3'd0;
      end
      M_BCOMMENT: begin
        if (c == C_NUL) begin
          emit(K_ERROR, E_COMMENT, lx_start, len_ex());
          lx_mode = M_IDLE;
          return 1'b1;
        end
        if (c == "*") lx_phase = 3'd1;
        else if (c == "/" && lx_phase != 3'd0) lx_mode = M_IDLE;
        else lx_phase = 3'd0;
      end
      default: begin
        lx_mode = M_IDLE;
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  // one accepted byte: advance the predictor and queue the token words it causes
  function automatic void lex_byte(logic [7:0] c);
    logic again, eof;
    step_words.delete();
    again = (lx_mode == M_IDLE) ? 1'b1 : lex_pending(c);
    eof = again ? lex_idle(c) : 1'b0;
    if (eof) lex_clear();
    else if (lx_pos != 24'hFFFFFF) lx_pos++;
    foreach (step_words[i]) begin
      step_words[i].last_of_run = (i == step_words.size() - 1);
      tokens_due = {tokens_due, step_words[i]};
    end
  endfunction

  // sender: hold the byte until it is taken, then at random idle for a random burst
  task automatic send_byte(input logic [7:0] b);
    in_if.valid <= 1'b1;
    in_if.data  <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    lex_byte(b);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // snippets of well-formed c with a few deliberate slips
  string frags[] = '{
    "case", "default", "do", "else", "enum", "for", "while", "if", "struct",
    "switch", "defaults", "_id9", "Zq", "0x1fUL", "1.5e+3", "2p-7", "3.E", "++",
    "--", "->", "+=", "-", "<<=", ">>", ">=", "<", ">", "!=", "!", "==", "=",
    "&&", "&=", "&", "|", "||", "|=", "%=", "^", "~", "##", "#", "...", "..x",
    ". ", "'a'", "'\\n'", "'ab'", "\"q\\\"z\"", "// c \\ \t\n d\n", "/* * / **/",
    "\r\n \t", "\r", "\n\t", "()[]{}\\;$:?,", "*=", "*", "/=", "/", " ", "\t"
  };

  task automatic send_fragment();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) send_byte(8'($urandom_range(1, 255)));   // noise
    else if (pick == 1 && $urandom_range(0, 3) == 0) send_byte(C_NUL);
    else send_text(frags[$urandom_range(0, frags.size() - 1)]);
  endtask

  // receiver: random stall bursts, one long hold-off on request
  int unsigned stall_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (hold_req && stall_left == 0) stall_left = LongHold;
      else if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 10);
      if (stall_left != 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // compare every token word taken from the block with the oldest expectation
  always @(posedge clk_i) begin
    out_word_t want, got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (tokens_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected word kind=%0d err=%0d start=%0d len=%0d last=%0d",
                 $time, got.token_kind, got.error_code, got.start_offset,
                 got.token_length, got.last_of_run);
      end else begin
        want = tokens_due.pop_front();
        if (got.token_kind != want.token_kind) begin
          errors++;
          $display("%0t: token_kind expected %0d actual %0d", $time,
                   want.token_kind, got.token_kind);
        end
        if (got.error_code != want.error_code) begin
          errors++;
          $display("%0t: error_code expected %0d actual %0d", $time,
                   want.error_code, got.error_code);
        end
        if (got.start_offset != want.start_offset) begin
          errors++;
          $display("%0t: start_offset expected %0d actual %0d", $time,
                   want.start_offset, got.start_offset);
        end
        if (got.token_length != want.token_length) begin
          errors++;
          $display("%0t: token_length expected %0d actual %0d", $time,
                   want.token_length, got.token_length);
        end
        if (got.last_of_run != want.last_of_run) begin
          errors++;
          $display("%0t: last_of_run expected %0d actual %0d", $time,
                   want.last_of_run, got.last_of_run);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // directed: keywords, operators, literals, dots, bad symbols, end of input
  task automatic test_directed();
    send_text("if(x->y<<=0x1fUL)");
    send_text("a..b '\\'' 'zz");
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(C_VT);
    send_byte(C_NUL);
  endtask

  // open constructs cut off by end of input
  task automatic test_open_at_end();
    send_text("/* x");
    send_byte(C_NUL);
    send_text("\"a\\");
    send_byte(C_NUL);
    send_text("'\\");
    send_byte(C_NUL);
    send_text("// x\\\n y");
    send_byte(C_NUL);
    send_text("switchy s");
    send_byte(C_NUL);
  endtask

  // random token streams with noise
  task automatic test_random_stream();
    for (int n = 0; n < 4; n++) send_fragment();
    send_byte(C_NUL);
  endtask

  // receiver holds off long while bytes that make many words keep coming
  task automatic test_backpressure();
    in_if.valid <= 1'b0;
    hold_req = 1'b1;
    wait (stall_left > LongHold / 2);
    hold_req = 1'b0;
    send_text("((;;..,..;{}[]?$:..y");
  endtask

  // last stretch: both sides run flat out
  task automatic test_full_rate();
    quiet = 1'b1;
    for (int n = 0; n < 4; n++) send_fragment();
    send_byte(C_NUL);
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.data  = '0;
    lex_clear();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_open_at_end();
    test_random_stream();
    test_backpressure();
    test_random_stream();
    test_full_rate();

    in_if.valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
